[hw/rtl/lfpa_pkg.sv]
// Shared constants, types and helpers for the linked free page allocator.
package lfpa_pkg;

   // Width of a frame index field; values at or above the frame count mean null.
   localparam int FIELD_W = 7;
   // Width of a physical frame address.
   localparam int ADDR_W = 27;
   // The link table always has this many entries, whatever the frame count.
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   // Defaults for the top-level parameters.
   localparam int FRAME_COUNT_DEFAULT = 64;
   localparam int PAGE_SHIFT_DEFAULT = 21;

   // The null frame marker.
   localparam logic [FIELD_W-1:0] NULL_FRAME = 7'd64;

   // Result status codes.
   localparam logic [1:0] STATUS_GRANT   = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_FREED   = 2'd2;

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;          // capture the request word
      logic rd_en;         // read the link of the current or walked frame
      logic alloc_step;    // grant the current frame and advance
      logic alloc_finish;  // cut the granted chain and move the free head
      logic walk_step;     // follow one link of the chain being freed
      logic free_splice;   // join the freed chain to the free list
      logic emit_refuse;   // report a refused allocation
      logic emit_free;     // report a free of a null chain
   } lfpa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_free;
      logic count_zero;
      logic list_empty;
      logic chain_null;
      logic alloc_last;
      logic walk_end;
   } lfpa_status_type;

   // A value names a real frame only when it lies below the frame count.
   function automatic logic is_frame(input logic [FIELD_W-1:0] value,
                                     input logic [FIELD_W-1:0] limit);
      return value < limit;
   endfunction

endpackage

[hw/rtl/lfpa_link_table.sv]
// Next-link table: one link per frame, with per-entry valid bits standing in for reset values.
module lfpa_link_table #(
   parameter int FRAME_COUNT = lfpa_pkg::FRAME_COUNT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [lfpa_pkg::IDX_W-1:0]    rd_addr,
   input  logic                          wr_en,
   input  logic [lfpa_pkg::IDX_W-1:0]    wr_addr,
   input  logic [lfpa_pkg::FIELD_W-1:0]  wr_data,
   output logic [lfpa_pkg::FIELD_W-1:0]  rd_data
);

   logic [lfpa_pkg::FIELD_W-1:0] mem [lfpa_pkg::TABLE_DEPTH];
   logic [lfpa_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic [lfpa_pkg::FIELD_W-1:0] rd_data_ff;
   logic [lfpa_pkg::IDX_W-1:0]   rd_addr_ff;
   logic                         rd_valid_ff;
   logic [lfpa_pkg::FIELD_W-1:0] reset_link;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // Valid bits: an entry becomes valid once written; reset clears them all at once.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // An unwritten entry links to the next frame, and the final frame links to null.
   always_comb begin
      if (rd_addr_ff < lfpa_pkg::IDX_W'(FRAME_COUNT - 1)) begin
         reset_link = lfpa_pkg::FIELD_W'(rd_addr_ff) + 1'b1;
      end else begin
         reset_link = lfpa_pkg::NULL_FRAME;
      end
      rd_data = rd_valid_ff ? rd_data_ff : reset_link;
   end

endmodule

[hw/rtl/lfpa_datapath.sv]
// Datapath: request registers, free head, walk registers, link table and result word.
module lfpa_datapath #(
   parameter int FRAME_COUNT = lfpa_pkg::FRAME_COUNT_DEFAULT,
   parameter int PAGE_SHIFT  = lfpa_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lfpa_pkg::lfpa_cmd_type        cmd,
   output lfpa_pkg::lfpa_status_type     status,
   input  logic                          req_operation,
   input  logic [lfpa_pkg::FIELD_W-1:0]  req_page_count,
   input  logic [lfpa_pkg::FIELD_W-1:0]  req_chain_head,
   output logic                          rsp_valid,
   output logic [lfpa_pkg::FIELD_W-1:0]  rsp_frame_index,
   output logic [lfpa_pkg::ADDR_W-1:0]   rsp_frame_address,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);

   localparam logic [lfpa_pkg::FIELD_W-1:0] LIMIT = lfpa_pkg::FIELD_W'(FRAME_COUNT);
   localparam logic [lfpa_pkg::IDX_W-1:0] MAX_STEPS = lfpa_pkg::IDX_W'(FRAME_COUNT - 1);

   logic                           op_ff;
   logic [lfpa_pkg::FIELD_W-1:0]   count_ff;
   logic [lfpa_pkg::FIELD_W-1:0]   head_ff;
   logic [lfpa_pkg::FIELD_W-1:0]   cur_ff, cur_in;
   logic [lfpa_pkg::FIELD_W-1:0]   n_ff, n_in;
   logic [lfpa_pkg::IDX_W-1:0]     walk_ff, walk_in;
   logic [lfpa_pkg::IDX_W-1:0]     steps_ff, steps_in;
   logic [lfpa_pkg::FIELD_W-1:0]   free_head_ff, free_head_in;
   logic [lfpa_pkg::FIELD_W-1:0]   nxt;
   logic [lfpa_pkg::FIELD_W-1:0]   n_plus;
   logic                           tbl_wr_en;
   logic [lfpa_pkg::IDX_W-1:0]     tbl_wr_addr;
   logic [lfpa_pkg::FIELD_W-1:0]   tbl_wr_data;
   logic [lfpa_pkg::IDX_W-1:0]     tbl_rd_addr;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lfpa_pkg::FIELD_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [lfpa_pkg::ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Link table; an allocate reads the current frame, a free reads the walk position.
   assign tbl_rd_addr = (op_ff == lfpa_pkg::OP_FREE) ? walk_ff
                                                      : cur_ff[lfpa_pkg::IDX_W-1:0];
   assign tbl_wr_en   = cmd.alloc_finish | cmd.free_splice;
   assign tbl_wr_addr = cmd.free_splice ? walk_ff : cur_ff[lfpa_pkg::IDX_W-1:0];
   assign tbl_wr_data = cmd.free_splice
      ? (lfpa_pkg::is_frame(free_head_ff, LIMIT) ? free_head_ff : lfpa_pkg::NULL_FRAME)
      : lfpa_pkg::NULL_FRAME;

   lfpa_link_table #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_link_table (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (cmd.rd_en),
      .rd_addr (tbl_rd_addr),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_data (nxt)
   );

   // Status for the controller.
   assign n_plus = n_ff + 1'b1;
   always_comb begin
      status.op_free    = (op_ff == lfpa_pkg::OP_FREE);
      status.count_zero = (count_ff == '0);
      status.list_empty = !lfpa_pkg::is_frame(free_head_ff, LIMIT);
      status.chain_null = !lfpa_pkg::is_frame(head_ff, LIMIT);
      status.alloc_last = (n_plus >= count_ff) || (n_plus >= LIMIT)
                          || !lfpa_pkg::is_frame(nxt, LIMIT);
      status.walk_end   = (steps_ff >= MAX_STEPS) || !lfpa_pkg::is_frame(nxt, LIMIT);
   end

   // Request capture and walk registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_operation;
         count_ff <= req_page_count;
         head_ff  <= req_chain_head;
      end
      cur_ff   <= cur_in;
      n_ff     <= n_in;
      walk_ff  <= walk_in;
      steps_ff <= steps_in;
   end

   always_comb begin
      cur_in   = cur_ff;
      n_in     = n_ff;
      walk_in  = walk_ff;
      steps_in = steps_ff;
      if (cmd.load) begin
         cur_in   = free_head_ff;
         n_in     = '0;
         walk_in  = req_chain_head[lfpa_pkg::IDX_W-1:0];
         steps_in = '0;
      end
      if (cmd.alloc_step) begin
         cur_in = nxt;
         n_in   = n_plus;
      end
      if (cmd.walk_step) begin
         walk_in  = nxt[lfpa_pkg::IDX_W-1:0];
         steps_in = steps_ff + 1'b1;
      end
   end

   // Free list head: moves past the granted frames, or onto a freed chain.
   always_comb begin
      free_head_in = free_head_ff;
      if (cmd.alloc_finish) begin
         free_head_in = lfpa_pkg::is_frame(nxt, LIMIT) ? nxt : lfpa_pkg::NULL_FRAME;
      end else if (cmd.free_splice) begin
         free_head_in = head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
      end else begin
         free_head_ff <= free_head_in;
      end
   end

   // Result word, held for exactly one cycle.
   always_comb begin
      rsp_valid_in  = cmd.alloc_step | cmd.emit_refuse | cmd.emit_free | cmd.free_splice;
      rsp_index_in  = lfpa_pkg::NULL_FRAME;
      rsp_addr_in   = '0;
      rsp_status_in = lfpa_pkg::STATUS_FREED;
      rsp_last_in   = 1'b1;
      if (cmd.alloc_step) begin
         rsp_index_in  = cur_ff;
         rsp_addr_in   = lfpa_pkg::ADDR_W'(cur_ff) << PAGE_SHIFT;
         rsp_status_in = lfpa_pkg::STATUS_GRANT;
         rsp_last_in   = status.alloc_last;
      end else if (cmd.emit_refuse) begin
         rsp_status_in = lfpa_pkg::STATUS_REFUSED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_index_ff  <= rsp_index_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_index   = rsp_index_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

[hw/rtl/lfpa_ctrl.sv]
// Controller state machine: sequences request capture, grant steps and chain walks.
module lfpa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lfpa_pkg::lfpa_status_type  status,
   output lfpa_pkg::lfpa_cmd_type     cmd
);

   typedef enum logic [5:0] {
      ST_IDLE       = 6'b000001,
      ST_CHECK      = 6'b000010,
      ST_ALLOC_READ = 6'b000100,
      ST_ALLOC_EMIT = 6'b001000,
      ST_FREE_READ  = 6'b010000,
      ST_FREE_STEP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.op_free) begin
               if (status.count_zero || status.list_empty) begin
                  cmd.emit_refuse = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_ALLOC_READ;
               end
            end else begin
               if (status.chain_null) begin
                  cmd.emit_free = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_FREE_READ;
               end
            end
         end
         ST_ALLOC_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_ALLOC_EMIT;
         end
         ST_ALLOC_EMIT: begin
            cmd.alloc_step = 1'b1;
            if (status.alloc_last) begin
               cmd.alloc_finish = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               state_in = ST_ALLOC_READ;
            end
         end
         ST_FREE_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_FREE_STEP;
         end
         ST_FREE_STEP: begin
            if (status.walk_end) begin
               cmd.free_splice = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
               state_in      = ST_FREE_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/linked_free_page_allocator.sv]
// A refused allocate or a null free gives its single word from the check state, registered.
// An allocate alternates a link read and a grant, one frame per grant, until the last frame.
// A free alternates a link read and a walk step, and gives its word when it splices the chain.
// Rate is set by the single read port of the link table: one table read per frame or link.
// Reset clears the controller, sets the free head to frame 0 and clears the table valid bits,
// so the default links hold at once; there is no clearing pass. Results cannot be stalled.
module linked_free_page_allocator #(
   parameter int FRAME_COUNT = lfpa_pkg::FRAME_COUNT_DEFAULT,
   parameter int PAGE_SHIFT  = lfpa_pkg::PAGE_SHIFT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_operation,
   input  logic [lfpa_pkg::FIELD_W-1:0]  req_page_count,
   input  logic [lfpa_pkg::FIELD_W-1:0]  req_chain_head,
   output logic                          rsp_valid,
   output logic [lfpa_pkg::FIELD_W-1:0]  rsp_frame_index,
   output logic [lfpa_pkg::ADDR_W-1:0]   rsp_frame_address,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);

   lfpa_pkg::lfpa_cmd_type    cmd;
   lfpa_pkg::lfpa_status_type status;

   // Controller.
   lfpa_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Datapath.
   lfpa_datapath #(
      .FRAME_COUNT (FRAME_COUNT),
      .PAGE_SHIFT  (PAGE_SHIFT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_page_count    (req_page_count),
      .req_chain_head    (req_chain_head),
      .rsp_valid         (rsp_valid),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_frame_address (rsp_frame_address),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   // A word only ever follows a cycle in which a request was in progress.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result word without a request in progress");

   // A taken request keeps the block busy in the next cycle.
   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken but block not busy");

   // Refusals and free reports are single words.
   a_single_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != lfpa_pkg::STATUS_GRANT) |-> rsp_last)
      else $error("refusal or free report not marked last");

   // A granted frame is always a real frame.
   a_grant_is_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == lfpa_pkg::STATUS_GRANT)
         |-> (rsp_frame_index < lfpa_pkg::FIELD_W'(FRAME_COUNT)))
      else $error("granted frame index out of range");

endmodule
